### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, off during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, active through reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/tcc_pkg.sv
// Shared constants, types and helper functions of the text console.
package tcc_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [ROW_W:0]  ROWS_X = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]  COLS_X = (COL_W + 1)'(COLUMNS);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'd7;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } tcc_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_FILL,
    ST_DONE
  } tcc_state_t;

  typedef struct packed {
    tcc_cmd_t    command;
    logic [7:0]  char_code;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
  } tcc_item_t;

  typedef struct packed {
    logic        scrolled;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] cell_word;
  } tcc_result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
  } tcc_mem_req_t;

  // Attribute in the high byte, character in the low byte.
  function automatic logic [15:0] make_cell(logic [7:0] color, logic [7:0] code);
    return {color, code};
  endfunction

  // Map a screen row and column to a memory address; the rows form a ring
  // that starts at the physical row top.
  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] top,
                                                  logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= ROWS_X) begin
      sum = sum - ROWS_X;
    end
    return ADDR_W'(ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
  endfunction

endpackage

### rtl/tcc_ram.sv
// Generic single-port RAM with registered read data.
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/tcc_ctrl.sv
// Command sequencer: cursor, scroll ring pointer, row blanking and screen fill.
module tcc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  tcc_pkg::tcc_item_t    item,
  output logic                  ready,
  input  logic [7:0]            text_color,
  output logic                  result_valid,
  output tcc_pkg::tcc_result_t  result,
  input  logic                  result_take,
  output tcc_pkg::tcc_mem_req_t mem_req,
  input  logic [15:0]           mem_rdata
);
  import tcc_pkg::*;

  tcc_state_t        state, state_next;
  logic              init_pass;
  tcc_cmd_t          cmd;
  logic [7:0]        ch;
  logic [4:0]        rrow;
  logic [6:0]        rcol;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  top_row;
  logic [ADDR_W-1:0] fill_addr;
  logic [ADDR_W-1:0] fill_end;
  logic [15:0]       fill_word;
  logic [15:0]       res_word;
  logic              res_scrolled;

  logic [COL_W:0]    col_inc;
  logic              col_wrap;
  logic              is_newline;
  logic              row_step;
  logic              scroll_now;
  logic              in_range;
  logic              fill_last;
  logic [ROW_W-1:0]  top_inc;
  logic [15:0]       put_cell;

  // Decode the current item
  assign col_inc    = {1'b0, cur_col} + 1'b1;
  assign col_wrap   = (col_inc == COLS_X);
  assign is_newline = (ch == NEWLINE_CODE);
  assign row_step   = (cmd == CMD_PUT) && (is_newline || col_wrap);
  assign scroll_now = row_step && (cur_row == ROW_W'(ROWS - 1));
  assign in_range   = (int'(rrow) < ROWS) && (int'(rcol) < COLUMNS);
  assign fill_last  = (fill_addr == fill_end);
  assign top_inc    = (top_row == ROW_W'(ROWS - 1)) ? '0 : top_row + 1'b1;
  assign put_cell   = make_cell(text_color, ch);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd)
          CMD_PUT:   state_next = scroll_now ? ST_FILL : ST_DONE;
          CMD_READ:  state_next = in_range ? ST_READ_WAIT : ST_DONE;
          CMD_CLEAR: state_next = ST_FILL;
          CMD_NONE:  state_next = ST_DONE;
        endcase
      end
      ST_READ_WAIT: state_next = ST_DONE;
      ST_FILL: begin
        if (fill_last) begin
          state_next = init_pass ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (result_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port, handshake and result
  always_comb begin
    mem_req       = '0;
    mem_req.addr  = cell_addr(top_row, cur_row, cur_col);
    mem_req.wdata = put_cell;
    ready         = (state == ST_IDLE);
    result_valid  = (state == ST_DONE);
    unique case (state)
      ST_EXEC: begin
        if (cmd == CMD_PUT && !is_newline) begin
          mem_req.we = 1'b1;
        end else if (cmd == CMD_READ) begin
          mem_req.addr = cell_addr(top_row, ROW_W'(rrow), COL_W'(rcol));
        end
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = fill_addr;
        mem_req.wdata = fill_word;
      end
      default: ;
    endcase
  end

  assign result.cell_word  = res_word;
  assign result.cursor_row = 5'(cur_row);
  assign result.cursor_col = 7'(cur_col);
  assign result.scrolled   = res_scrolled;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // Cursor, ring pointer and fill sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      init_pass <= 1'b1;
      cur_row   <= '0;
      cur_col   <= '0;
      top_row   <= '0;
      fill_addr <= '0;
      fill_end  <= ADDR_W'(CELLS - 1);
      fill_word <= make_cell(RESET_COLOR, SPACE_CODE);
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cmd          <= item.command;
            ch           <= item.char_code;
            rrow         <= item.read_row;
            rcol         <= item.read_col;
            res_word     <= '0;
            res_scrolled <= 1'b0;
          end
        end
        ST_EXEC: begin
          unique case (cmd)
            CMD_PUT: begin
              if (!is_newline) begin
                res_word <= put_cell;
              end
              // advance column, wrap to next row
              if (is_newline || col_wrap) begin
                cur_col <= '0;
              end else begin
                cur_col <= col_inc[COL_W-1:0];
              end
              if (scroll_now) begin
                // old top row becomes the blank bottom row
                top_row      <= top_inc;
                fill_addr    <= cell_addr(top_row, '0, '0);
                fill_end     <= cell_addr(top_row, '0, COL_W'(COLUMNS - 1));
                fill_word    <= make_cell(text_color, SPACE_CODE);
                res_scrolled <= 1'b1;
              end else if (row_step) begin
                cur_row <= cur_row + 1'b1;
              end
            end
            CMD_CLEAR: begin
              cur_row   <= '0;
              cur_col   <= '0;
              top_row   <= '0;
              fill_addr <= '0;
              fill_end  <= ADDR_W'(CELLS - 1);
              fill_word <= make_cell(text_color, SPACE_CODE);
            end
            CMD_READ: ;
            CMD_NONE: ;
          endcase
        end
        ST_READ_WAIT: res_word <= mem_rdata;
        ST_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_last) begin
            init_pass <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/text_console_cursor_scroll.sv
// Text console top level: stream ports, color register, output register.
//
//   channel   signals                           direction
//   s_        s_tvalid s_tready s_tdata s_tuser in:  one command word
//   m_        m_tvalid m_tready m_tdata         out: one result word per command
//   cfg_      cfg_we cfg_wdata                  in:  text color register
//
// From the accepting edge to m_tvalid a command passes ST_EXEC and ST_DONE,
// where the output register takes the result. Between the two, a scrolling put
// passes ST_FILL (blanks one row, one cell a cycle through the single RAM port),
// a read in range ST_READ_WAIT, a clear ST_FILL over all ROWS*COLUMNS cells.
// s_tready rises with m_tvalid. After reset the screen RAM is filled with
// spaces, with s_tready low. A stalled result waits in the output register.
module text_console_cursor_scroll (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cell_word[15:0], cursor_row[20:16],
                                 // cursor_col[27:21], scrolled[28]
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import tcc_pkg::*;

  logic         [7:0]  text_color;
  tcc_item_t           item;
  logic                ctrl_ready;
  logic                res_valid;
  tcc_result_t         res;
  logic                res_take;
  tcc_mem_req_t        mem_req;
  logic         [15:0] mem_rdata;

  // Unpack the input word
  assign item.command   = tcc_cmd_t'(s_tuser);
  assign item.char_code = s_tdata[7:0];
  assign item.read_row  = s_tdata[12:8];
  assign item.read_col  = s_tdata[19:13];
  assign s_tready       = ctrl_ready;

  // Hold the text color
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  // Output register: load when empty or draining
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {3'b000, res};
    end
  end

  tcc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (s_tvalid && ctrl_ready),
    .item         (item),
    .ready        (ctrl_ready),
    .text_color   (text_color),
    .result_valid (res_valid),
    .result       (res),
    .result_take  (res_take),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  tcc_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

endmodule

### rtl/tcc_checker.sv
// Port-level checks of the text console and their bind to the top level.
`include "assert_macros.svh"

module tcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import tcc_pkg::*;

  logic       out_scrolled;
  logic [6:0] out_col;
  logic [4:0] out_row;

  // Split the result word
  assign out_scrolled = m_tdata[28];
  assign out_col      = m_tdata[27:21];
  assign out_row      = m_tdata[20:16];

  // A stalled result word holds
  `ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // One command at a time: no accept right after an accept
  `ASSERT_NXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)

  // A scroll leaves the cursor at the start of the bottom row
  `ASSERT_IMP(a_scroll_pos, clk, rst, m_tvalid && out_scrolled, out_col == 7'd0 && out_row == 5'(ROWS - 1))

  // The screen fill after reset blocks input
  `ASSERT_NXT_ALWAYS(a_reset_fill, clk, rst, !s_tready)

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (.*);
